// ----- src/kvtl_pkg.sv -----
`default_nettype none

package kvtl_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int KEY_BITS    = 8;
    localparam int VALUE_BITS  = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Stream payload widths (padded to whole bytes)
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    // Action codes
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_ERASE  = 2'd1;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    // Write request into the entry store
    typedef struct packed {
        logic                  en;
        logic [IDX_W-1:0]      addr;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } wr_req_t;

endpackage

`default_nettype wire

// ----- src/kvtl_store.sv -----
`default_nettype none

module kvtl_store (
    input  wire logic                              aclk,
    input  wire kvtl_pkg::wr_req_t                 wr,
    input  wire logic [kvtl_pkg::IDX_W-1:0]        rd_addr,
    output logic      [kvtl_pkg::KEY_BITS-1:0]     rd_key,
    output logic      [kvtl_pkg::VALUE_BITS-1:0]   rd_value
);

    logic [kvtl_pkg::KEY_BITS-1:0]   key_mem   [kvtl_pkg::TABLE_DEPTH];
    logic [kvtl_pkg::VALUE_BITS-1:0] value_mem [kvtl_pkg::TABLE_DEPTH];
    logic [kvtl_pkg::KEY_BITS-1:0]   rd_key_reg;
    logic [kvtl_pkg::VALUE_BITS-1:0] rd_value_reg;

    // Write one entry per cycle
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            key_mem[wr.addr]   <= wr.key;
            value_mem[wr.addr] <= wr.value;
        end
    end

    // Registered read of one entry
    always_ff @(posedge aclk) begin
        rd_key_reg   <= key_mem[rd_addr];
        rd_value_reg <= value_mem[rd_addr];
    end

    assign rd_key   = rd_key_reg;
    assign rd_value = rd_value_reg;

endmodule

`default_nettype wire

// ----- src/key_value_table_linear_unit.sv -----
`default_nettype none

// Channel   Dir  tdata fields (low bit up)                          Width
// s_axis    in   action[1:0], lookup_key[9:2], new_value[41:10]       48
// m_axis    out  status[1:0], found_value[33:2], live_count[38:34]     40
//
// Insert and the unused action code go from accept straight to the response state.
// Lookup and erase scan one entry per cycle through the registered store read; an
// erase hit then moves each later entry down by one place before the response.
// s_tready is high only while the sequencer is idle; a result held in the output
// register stalls only the next response. Reset clears the count, not the store.

module key_value_table_linear_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [kvtl_pkg::S_TDATA_W-1:0]    s_tdata,  // action, lookup_key, new_value
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [kvtl_pkg::M_TDATA_W-1:0]    m_tdata   // status, found_value, live_count
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_SHIFT  = 4'b0100,
        ST_RESP   = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [kvtl_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [kvtl_pkg::CNT_W-1:0]      scan_reg, scan_next;
    logic                            pend_reg, pend_next;
    logic [kvtl_pkg::IDX_W-1:0]      pend_idx_reg, pend_idx_next;
    logic [1:0]                      action_reg, action_next;
    logic [kvtl_pkg::KEY_BITS-1:0]   key_reg, key_next;
    logic [1:0]                      res_status_reg, res_status_next;
    logic [kvtl_pkg::VALUE_BITS-1:0] res_value_reg, res_value_next;
    logic                            m_valid_reg, m_valid_next;
    logic [kvtl_pkg::M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    kvtl_pkg::wr_req_t               wr;
    logic [kvtl_pkg::IDX_W-1:0]      rd_addr;
    logic [kvtl_pkg::KEY_BITS-1:0]   rd_key;
    logic [kvtl_pkg::VALUE_BITS-1:0] rd_value;

    logic [1:0]                      in_action;
    logic [kvtl_pkg::KEY_BITS-1:0]   in_key;
    logic [kvtl_pkg::VALUE_BITS-1:0] in_value;
    logic                            key_match;

    assign in_action = s_tdata[1:0];
    assign in_key    = s_tdata[9:2];
    assign in_value  = s_tdata[41:10];

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_tdata_reg;

    // Shared store: one read port walked by the scan pointer
    assign rd_addr   = scan_reg[kvtl_pkg::IDX_W-1:0];
    assign key_match = pend_reg && (rd_key == key_reg);

    kvtl_store u_store (
        .aclk     (aclk),
        .wr       (wr),
        .rd_addr  (rd_addr),
        .rd_key   (rd_key),
        .rd_value (rd_value)
    );

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        action_next     = action_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        wr              = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    action_next     = in_action;
                    key_next        = in_key;
                    res_value_next  = '0;
                    res_status_next = kvtl_pkg::STAT_DONE;
                    scan_next       = '0;
                    pend_next       = 1'b0;
                    case (in_action)
                        kvtl_pkg::ACT_INSERT: begin
                            if (count_reg >= kvtl_pkg::CNT_W'(kvtl_pkg::TABLE_DEPTH)) begin
                                res_status_next = kvtl_pkg::STAT_FULL;
                            end else begin
                                wr.en      = 1'b1;
                                wr.addr    = count_reg[kvtl_pkg::IDX_W-1:0];
                                wr.key     = in_key;
                                wr.value   = in_value;
                                count_next = count_reg + kvtl_pkg::CNT_W'(1);
                            end
                            state_next = ST_RESP;
                        end
                        kvtl_pkg::ACT_ERASE, kvtl_pkg::ACT_LOOKUP: begin
                            state_next = ST_SEARCH;
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_SEARCH: begin
                // Compare the entry read last cycle while issuing the next read
                if (key_match) begin
                    if (action_reg == kvtl_pkg::ACT_LOOKUP) begin
                        res_value_next = rd_value;
                        state_next     = ST_RESP;
                    end else begin
                        scan_next  = {1'b0, pend_idx_reg} + kvtl_pkg::CNT_W'(1);
                        pend_next  = 1'b0;
                        state_next = ST_SHIFT;
                    end
                end else if (scan_reg < count_reg) begin
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg[kvtl_pkg::IDX_W-1:0];
                    scan_next     = scan_reg + kvtl_pkg::CNT_W'(1);
                end else begin
                    res_status_next = kvtl_pkg::STAT_NOT_FOUND;
                    state_next      = ST_RESP;
                end
            end

            ST_SHIFT: begin
                // Move the entry read last cycle down by one place
                if (pend_reg) begin
                    wr.en    = 1'b1;
                    wr.addr  = pend_idx_reg - kvtl_pkg::IDX_W'(1);
                    wr.key   = rd_key;
                    wr.value = rd_value;
                end
                if (scan_reg < count_reg) begin
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg[kvtl_pkg::IDX_W-1:0];
                    scan_next     = scan_reg + kvtl_pkg::CNT_W'(1);
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        count_next = count_reg - kvtl_pkg::CNT_W'(1);
                        state_next = ST_RESP;
                    end
                end
            end

            ST_RESP: begin
                // Load the output register once it is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_tdata_next = {1'b0, count_reg, res_value_reg, res_status_reg};
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            scan_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            scan_reg    <= scan_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pend_idx_reg   <= pend_idx_next;
        action_reg     <= action_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        m_tdata_reg    <= m_tdata_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= kvtl_pkg::CNT_W'(kvtl_pkg::TABLE_DEPTH))
        else $error("entry count above table depth");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && in_action == kvtl_pkg::ACT_INSERT &&
         count_reg < kvtl_pkg::CNT_W'(kvtl_pkg::TABLE_DEPTH))
        |=> (count_reg == $past(count_reg) + kvtl_pkg::CNT_W'(1)))
        else $error("insert did not add one entry");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH) |-> (scan_reg <= count_reg))
        else $error("search pointer past live entries");

    a_shift_above_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT && pend_reg) |-> (pend_idx_reg != '0))
        else $error("shift source at entry zero");

    a_result_after_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESP && state_next == ST_IDLE) |=> m_tvalid)
        else $error("result not presented after response");
`endif

endmodule

`default_nettype wire
